// ===== rtl/hcbp_pkg.sv =====
package hcbp_pkg;

   // Field widths fixed by the interface.
   localparam int SYMBOL_W = 8;
   localparam int CODE_W   = 32;
   localparam int LEN_W    = 6;
   localparam int BYTE_W   = 8;

   // Pending bits held between items, and the widest packing word.
   localparam int ACC_W   = 7;
   localparam int VALUE_W = CODE_W + ACC_W;

   // Depth of the work queue between front and back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      CMD_LOAD   = 2'd0,
      CMD_ENCODE = 2'd1,
      CMD_FLUSH  = 2'd2
   } hcbp_cmd_type;

   // One unit of work for the back end: a masked code with its length, or a flush.
   typedef struct packed {
      logic              flush;
      logic [LEN_W-1:0]  len;
      logic [CODE_W-1:0] code;
   } hcbp_work_type;

endpackage

// ===== rtl/huffman_code_bit_packer_core.sv =====
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  command, symbol, code_bits, code_length
// rsp_      out        rsp_valid/rsp_stall  out_byte, last
//
// A load or a dropped encode is consumed by the front end and yields no transfer.
// An encode first merges its code in the back end, which then sends one output byte per cycle
// unless rsp_stall holds the one-byte output register; new work waits until its whole bytes are out.
// The front end keeps accepting while the back end drains, until the four-entry queue fills.
// Reset clears the length valid bits at once; there is no clearing pass.
module huffman_code_bit_packer_core
   import hcbp_pkg::*;
#(
   parameter int SYMBOL_COUNT = 256,
   parameter int MAX_CODE_LEN = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_command,
   input  logic [SYMBOL_W-1:0] req_symbol,
   input  logic [CODE_W-1:0]   req_code_bits,
   input  logic [LEN_W-1:0]    req_code_length,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [BYTE_W-1:0]   rsp_out_byte,
   output logic                rsp_last
);

   logic          push_valid;
   logic          push_ready;
   hcbp_work_type push_data;
   logic          pop_valid;
   logic          pop_ready;
   hcbp_work_type pop_data;

   // Command decode and table lookup.
   hcbp_front #(
      .SYMBOL_COUNT (SYMBOL_COUNT),
      .MAX_CODE_LEN (MAX_CODE_LEN)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_symbol      (req_symbol),
      .req_code_bits   (req_code_bits),
      .req_code_length (req_code_length),
      .push_valid      (push_valid),
      .push_data       (push_data),
      .push_ready      (push_ready)
   );

   // Work queue.
   hcbp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop_ready  (pop_ready)
   );

   // Bit packing and byte output.
   hcbp_back u_back (
      .clock        (clock),
      .reset        (reset),
      .pop_valid    (pop_valid),
      .pop_data     (pop_data),
      .pop_ready    (pop_ready),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

endmodule

// ===== rtl/hcbp_front.sv =====
module hcbp_front
   import hcbp_pkg::*;
#(
   parameter int SYMBOL_COUNT = 256,
   parameter int MAX_CODE_LEN = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_command,
   input  logic [SYMBOL_W-1:0] req_symbol,
   input  logic [CODE_W-1:0]   req_code_bits,
   input  logic [LEN_W-1:0]    req_code_length,
   output logic                push_valid,
   output hcbp_work_type       push_data,
   input  logic                push_ready
);

   localparam int SYM_IDX_W = $clog2(SYMBOL_COUNT);
   localparam int LEN_CAP   = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

   logic                  accept;
   logic                  in_range;
   logic [SYM_IDX_W-1:0]  sym_idx;
   logic [LEN_W-1:0]      len_capped;
   logic                  is_load;
   logic                  is_encode;
   logic                  is_flush;
   logic                  s1_advance;
   logic                  s1_needs_push;
   logic [LEN_W-1:0]      s1_len;
   logic [CODE_W:0]       len_mask;

   logic [CODE_W-1:0]     code_mem [SYMBOL_COUNT];
   logic [LEN_W-1:0]      len_mem [SYMBOL_COUNT];
   logic [SYMBOL_COUNT-1:0] len_valid_ff;
   logic [SYMBOL_COUNT-1:0] len_valid_in;

   logic                  s1_valid_ff;
   logic                  s1_valid_in;
   logic                  s1_flush_ff;
   logic [CODE_W-1:0]     s1_code_ff;
   logic [LEN_W-1:0]      s1_len_ff;
   logic                  s1_len_ok_ff;

   // Decode the incoming command.
   always_comb begin
      is_load   = 1'b0;
      is_encode = 1'b0;
      is_flush  = 1'b0;
      case (req_command)
         CMD_LOAD:   is_load   = 1'b1;
         CMD_ENCODE: is_encode = 1'b1;
         CMD_FLUSH:  is_flush  = 1'b1;
         default:    ;
      endcase
   end

   assign in_range   = {1'b0, req_symbol} < (SYMBOL_W + 1)'(SYMBOL_COUNT);
   assign sym_idx    = req_symbol[SYM_IDX_W-1:0];
   assign len_capped = (req_code_length > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : req_code_length;

   // The lookup stage moves on unless it holds work that the queue cannot take.
   assign s1_len        = s1_len_ok_ff ? s1_len_ff : '0;
   assign s1_needs_push = s1_valid_ff && (s1_flush_ff || (s1_len != '0));
   assign s1_advance    = !s1_needs_push || push_ready;
   assign req_stall     = !s1_advance;
   assign accept        = req_valid && !req_stall;

   // Code table: written by a load, read when an encode is accepted.
   always_ff @(posedge clock) begin
      if (accept && is_load && in_range) begin
         code_mem[sym_idx] <= req_code_bits;
         len_mem[sym_idx]  <= len_capped;
      end
      if (accept) begin
         s1_code_ff   <= code_mem[sym_idx];
         s1_len_ff    <= len_mem[sym_idx];
         s1_len_ok_ff <= len_valid_ff[sym_idx];
         s1_flush_ff  <= is_flush;
      end
   end

   // A length entry that was never loaded reads as zero.
   always_comb begin
      len_valid_in = len_valid_ff;
      if (accept && is_load && in_range) begin
         len_valid_in[sym_idx] = 1'b1;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = is_flush || (is_encode && in_range);
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_valid_ff <= '0;
         s1_valid_ff  <= 1'b0;
      end else begin
         len_valid_ff <= len_valid_in;
         s1_valid_ff  <= s1_valid_in;
      end
   end

   // Hand the masked code to the queue.
   assign len_mask             = ((CODE_W + 1)'(1) << s1_len) - (CODE_W + 1)'(1);
   assign push_valid           = s1_needs_push;
   assign push_data.flush      = s1_flush_ff;
   assign push_data.len        = s1_len;
   assign push_data.code       = s1_code_ff & len_mask[CODE_W-1:0];

   // An accepted encode of a symbol in the table reaches the lookup stage.
   a_encode_looked_up: assert property (@(posedge clock) disable iff (reset)
      (accept && is_encode && in_range) |=> (s1_valid_ff && !s1_flush_ff))
      else $error("encode lost before lookup");

   // Work is never sent with zero length unless it is a flush.
   a_push_nonempty: assert property (@(posedge clock) disable iff (reset)
      (push_valid && !push_data.flush) |-> (push_data.len != '0))
      else $error("empty code pushed");

endmodule

// ===== rtl/hcbp_queue.sv =====
module hcbp_queue
   import hcbp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   input  hcbp_work_type push_data,
   output logic          push_ready,
   output logic          pop_valid,
   output hcbp_work_type pop_data,
   input  logic          pop_ready
);

   hcbp_work_type     entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_in;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;
   logic              do_push;
   logic              do_pop;

   assign push_ready = count_ff != QCNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Pointers and fill count.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // The fill count never passes the depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue overfilled");

   // The pointers stay apart by the fill count, modulo the queue depth.
   a_ptr_count: assert property (@(posedge clock) disable iff (reset)
      QPTR_W'(wr_ptr_ff - rd_ptr_ff) == count_ff[QPTR_W-1:0])
      else $error("queue pointers out of step");

endmodule

// ===== rtl/hcbp_back.sv =====
module hcbp_back
   import hcbp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   input  hcbp_work_type     pop_data,
   output logic              pop_ready,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [BYTE_W-1:0] rsp_out_byte,
   output logic              rsp_last
);

   localparam int TOTAL_W = $clog2(VALUE_W + 1);

   logic [VALUE_W-1:0] value_ff;
   logic [VALUE_W-1:0] value_in;
   logic [TOTAL_W-1:0] total_ff;
   logic [TOTAL_W-1:0] total_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [BYTE_W-1:0]  rsp_byte_ff;
   logic [BYTE_W-1:0]  rsp_byte_in;
   logic               rsp_last_ff;
   logic               rsp_last_in;

   logic               out_free;
   logic               has_byte;
   logic               emit_full;
   logic               emit_flush;
   logic               take;
   logic [2:0]         pend;
   logic [ACC_W-1:0]   acc;
   logic [VALUE_W-1:0] shifted;
   logic [BYTE_W-1:0]  flush_byte;

   // The output register frees when empty or when its byte is transferred.
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign has_byte = total_ff >= TOTAL_W'(BYTE_W);
   assign pend     = total_ff[2:0];
   assign acc      = value_ff[ACC_W-1:0] & ~(ACC_W'({ACC_W{1'b1}}) << pend);

   // New work is taken only once all whole bytes have left; a flush also needs the output.
   assign pop_ready  = !has_byte && (!pop_data.flush || out_free);
   assign take       = pop_valid && pop_ready;
   assign emit_full  = has_byte && out_free;
   assign emit_flush = take && pop_data.flush && (pend != '0);

   assign shifted    = value_ff >> (total_ff - TOTAL_W'(BYTE_W));
   assign flush_byte = BYTE_W'({1'b0, acc} << (4'd8 - {1'b0, pend}));

   // Packing word and pending bit count.
   always_comb begin
      value_in = value_ff;
      total_in = total_ff;
      if (emit_full) begin
         total_in = total_ff - TOTAL_W'(BYTE_W);
      end else if (take && pop_data.flush) begin
         total_in = '0;
      end else if (take) begin
         value_in = (VALUE_W'(acc) << pop_data.len) | VALUE_W'(pop_data.code);
         total_in = TOTAL_W'(pend) + TOTAL_W'(pop_data.len);
      end
   end

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit_full) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = shifted[BYTE_W-1:0];
         rsp_last_in  = total_ff < TOTAL_W'(2 * BYTE_W);
      end else if (emit_flush) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = flush_byte;
         rsp_last_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         value_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         total_ff     <= total_in;
         value_ff     <= value_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_last     = rsp_last_ff;

   // A byte marked last leaves fewer than eight bits pending.
   a_last_drains: assert property (@(posedge clock) disable iff (reset)
      (emit_full && rsp_last_in) |=> (total_ff < TOTAL_W'(BYTE_W)))
      else $error("bytes left after last");

   // The pending bit count never exceeds one code plus seven bits.
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= TOTAL_W'(VALUE_W))
      else $error("pending bit count out of range");

endmodule

// ===== bench/huffman_code_bit_packer_checker.sv =====
module huffman_code_bit_packer_checker
   import hcbp_pkg::*;
#(
   parameter int SYMBOL_COUNT = 256,
   parameter int MAX_CODE_LEN = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic [1:0]          req_command,
   input  logic [SYMBOL_W-1:0] req_symbol,
   input  logic [CODE_W-1:0]   req_code_bits,
   input  logic [LEN_W-1:0]    req_code_length,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [BYTE_W-1:0]   rsp_out_byte,
   input  logic                rsp_last,
   output int                  mismatch_count,
   output int                  bytes_outstanding,
   output int                  bytes_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   // Stored lengths saturate at the narrower of the parameter and the code field.
   localparam int LEN_CAP = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              last;
   } packed_byte_type;

   // Bytes the block still owes, oldest first.
   packed_byte_type expected_bytes[$];

   // Shadow copy of the code table and the bit accumulator.
   logic [CODE_W-1:0] code_table   [SYMBOL_COUNT];
   logic [LEN_W-1:0]  length_table [SYMBOL_COUNT];
   logic [ACC_W-1:0]  held_bits;
   int unsigned       held_count;

   // Apply one accepted request to the shadow state and queue the bytes it produces.
   task automatic pack_request(input logic [1:0] cmd, input logic [SYMBOL_W-1:0] sym,
                               input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len);
      int unsigned        n;
      int unsigned        total;
      logic [VALUE_W-1:0] word;
      logic [VALUE_W-1:0] mask;
      packed_byte_type    b;
      case (cmd)
         CMD_LOAD: begin
            if (sym < SYMBOL_COUNT) begin
               code_table[sym]   = code;
               length_table[sym] = (len > LEN_CAP) ? LEN_W'(LEN_CAP) : len;
            end
         end
         CMD_ENCODE: begin
            if (sym < SYMBOL_COUNT && length_table[sym] != '0) begin
               n     = 32'(length_table[sym]);
               total = held_count + n;
               mask  = (VALUE_W'(1) << n) - VALUE_W'(1);
               word  = (VALUE_W'(held_bits) << n) | (VALUE_W'(code_table[sym]) & mask);
               // Peel off whole bytes, earliest bits first.
               while (total >= BYTE_W) begin
                  total -= BYTE_W;
                  b.out_byte = BYTE_W'(word >> total);
                  b.last     = (total < BYTE_W);
                  expected_bytes.push_back(b);
               end
               held_bits  = ACC_W'(word & ((VALUE_W'(1) << total) - VALUE_W'(1)));
               held_count = total;
            end
         end
         CMD_FLUSH: begin
            // Pending bits go out left-justified, zero-padded below.
            if (held_count != 0) begin
               b.out_byte = BYTE_W'(VALUE_W'(held_bits) << (BYTE_W - held_count));
               b.last     = 1'b1;
               expected_bytes.push_back(b);
               held_bits  = '0;
               held_count = 0;
            end
         end
         default: ;
      endcase
   endtask

   // Compare output transfers first, then fold in the request accepted at the same edge.
   always @(posedge clock) begin : watch
      packed_byte_type want;
      if (reset) begin
         for (int i = 0; i < SYMBOL_COUNT; i++) length_table[i] = '0;
         held_bits  = '0;
         held_count = 0;
         expected_bytes.delete();
         mismatch_count = 0;
         bytes_checked  = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_bytes.size() == 0) begin
               $error("unexpected output transfer: out_byte 8'h%02h last %0b",
                      rsp_out_byte, rsp_last);
               mismatch_count++;
            end else begin
               want = expected_bytes.pop_front();
               bytes_checked++;
               if (rsp_out_byte !== want.out_byte) begin
                  $error("out_byte mismatch: expected 8'h%02h, actual 8'h%02h",
                         want.out_byte, rsp_out_byte);
                  mismatch_count++;
               end
               if (rsp_last !== want.last) begin
                  $error("last mismatch: expected %0b, actual %0b", want.last, rsp_last);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && !req_stall)
            pack_request(req_command, req_symbol, req_code_bits, req_code_length);
      end
      bytes_outstanding = expected_bytes.size();
   end

endmodule

// ===== bench/huffman_code_bit_packer_core_tb.sv =====
module huffman_code_bit_packer_core_tb
   import hcbp_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam time        CLOCK_PERIOD    = 8ns;
   localparam logic [1:0] CMD_UNUSED      = 2'd3;
   localparam int         ITEMS_PER_PHASE = 45;
   localparam int         DRAIN_CYCLES    = 16;
   // A correct run never goes this long without a transfer, even at the heaviest idling.
   localparam int         STALL_LIMIT     = 2000;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [1:0]          req_command = CMD_LOAD;
   logic [SYMBOL_W-1:0] req_symbol = '0;
   logic [CODE_W-1:0]   req_code_bits = '0;
   logic [LEN_W-1:0]    req_code_length = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [BYTE_W-1:0]   rsp_out_byte;
   logic                rsp_last;

   int mismatch_count;
   int bytes_outstanding;
   int bytes_checked;

   // Idle percentages for the request sender and the byte receiver.
   int unsigned send_idle_pct = 21;
   int unsigned recv_idle_pct = 62;

   int unsigned loads_sent;
   int unsigned encodes_sent;
   int unsigned flushes_sent;
   int unsigned ignored_sent;
   int unsigned quiet_cycles;

   // Symbols that currently hold a nonzero code length, as far as the stimulus knows.
   logic                has_code [256];
   logic [SYMBOL_W-1:0] coded_syms[$];

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   huffman_code_bit_packer_core u_dut (.*);

   huffman_code_bit_packer_checker u_checker (.*);

   // Random backpressure on the byte channel.
   always @(negedge clock)
      rsp_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);

   // Watchdog on cycles with no transfer on either channel.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // Present one request, wait for its transfer, and return at a falling edge.
   task automatic send_request(input logic [1:0] cmd, input logic [SYMBOL_W-1:0] sym,
                               input logic [CODE_W-1:0] code,
                               input logic [LEN_W-1:0] len);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_command     <= cmd;
      req_symbol      <= sym;
      req_code_bits   <= code;
      req_code_length <= len;
      req_valid       <= 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      case (cmd)
         CMD_LOAD: begin
            loads_sent++;
            has_code[sym] = (len != '0);
            if (len != '0) coded_syms.push_back(sym);
         end
         CMD_ENCODE: begin
            if (has_code[sym]) encodes_sent++;
            else ignored_sent++;
         end
         CMD_FLUSH: flushes_sent++;
         default:   ignored_sent++;
      endcase
   endtask

   initial begin : stimulus
      int unsigned         counted;
      int unsigned         pick;
      logic [1:0]          cmd;
      logic [SYMBOL_W-1:0] sym;
      logic [LEN_W-1:0]    len;
      for (int i = 0; i < 256; i++) has_code[i] = 1'b0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty table, empty flush, unused command, extreme and overlong lengths,
      // stray code bits, zero-length entries and the widest accumulator fill.
      send_request(CMD_ENCODE, 8'h00, 32'h0000_0000, 6'd0);
      send_request(CMD_FLUSH,  8'h00, 32'h0000_0000, 6'd0);
      send_request(CMD_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
      send_request(CMD_LOAD,   8'h00, 32'hFFFF_FFFF, 6'd32);
      send_request(CMD_LOAD,   8'hFF, 32'hA5A5_A5A5, 6'd63);
      send_request(CMD_LOAD,   8'h01, 32'hFFFF_FFFE, 6'd1);
      send_request(CMD_LOAD,   8'h02, 32'h0000_0005, 6'd3);
      send_request(CMD_LOAD,   8'h80, 32'h0000_0000, 6'd33);
      send_request(CMD_LOAD,   8'h7F, 32'h1234_5678, 6'd0);
      send_request(CMD_LOAD,   8'h55, 32'hFFFF_FFAA, 6'd8);
      send_request(CMD_ENCODE, 8'h55, 32'h0000_0000, 6'd0);
      send_request(CMD_ENCODE, 8'h01, 32'hFFFF_FFFF, 6'h3F);
      send_request(CMD_ENCODE, 8'hFF, 32'h0000_0000, 6'd0);
      send_request(CMD_ENCODE, 8'h00, 32'h0000_0000, 6'd0);
      send_request(CMD_ENCODE, 8'h7F, 32'h0000_0000, 6'd0);
      send_request(CMD_ENCODE, 8'h02, 32'h0000_0000, 6'd0);
      send_request(CMD_ENCODE, 8'h02, 32'h0000_0000, 6'd0);
      send_request(CMD_ENCODE, 8'h00, 32'h0000_0000, 6'd0);
      send_request(CMD_FLUSH,  8'hFF, 32'hFFFF_FFFF, 6'h3F);
      send_request(CMD_ENCODE, 8'h80, 32'h0000_0000, 6'd0);
      send_request(CMD_ENCODE, 8'h02, 32'h0000_0000, 6'd0);
      send_request(CMD_FLUSH,  8'h00, 32'h0000_0000, 6'd0);
      send_request(CMD_FLUSH,  8'h00, 32'h0000_0000, 6'd0);
      send_request(CMD_LOAD,   8'h55, 32'hFFFF_FFFF, 6'd0);
      send_request(CMD_ENCODE, 8'h55, 32'h0000_0000, 6'd0);

      // Random: mostly encodes of coded symbols, with table reloads, flushes and noise.
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0:       begin send_idle_pct = 21; recv_idle_pct = 62; end
            1:       begin send_idle_pct = 62; recv_idle_pct = 21; end
            default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
         endcase
         counted = 0;
         while (counted < ITEMS_PER_PHASE) begin
            pick = $urandom_range(99);
            sym  = SYMBOL_W'($urandom_range(255));
            len  = LEN_W'($urandom_range(63));
            if (pick < 14 || coded_syms.size() == 0) begin
               cmd  = CMD_LOAD;
               // Short codes dominate, as in a real table, with some long and overlong ones.
               pick = $urandom_range(99);
               if (pick < 4)       len = '0;
               else if (pick < 8)  len = LEN_W'($urandom_range(63, 33));
               else if (pick < 25) len = LEN_W'($urandom_range(32, 13));
               else                len = LEN_W'($urandom_range(12, 1));
            end else if (pick < 86) begin
               cmd = CMD_ENCODE;
               if ($urandom_range(9) != 0)
                  sym = coded_syms[$urandom_range(coded_syms.size() - 1)];
            end else if (pick < 96) begin
               cmd = CMD_FLUSH;
            end else begin
               cmd = CMD_UNUSED;
            end
            counted++;
            send_request(cmd, sym, $urandom(), len);
         end
      end
      send_request(CMD_FLUSH, 8'h00, 32'h0000_0000, 6'd0);
      req_valid <= 1'b0;

      // Let every owed byte arrive, then watch a little longer for strays.
      while (bytes_outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Sent %0d loads, %0d encodes of coded symbols, %0d flushes, %0d ignored requests;",
               loads_sent, encodes_sent, flushes_sent, ignored_sent);
      $display("checked %0d packed bytes over three idle patterns.", bytes_checked);
      if (mismatch_count == 0 && bytes_outstanding == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== huffman_code_bit_packer_core.f =====
rtl/hcbp_pkg.sv
rtl/hcbp_front.sv
rtl/hcbp_queue.sv
rtl/hcbp_back.sv
rtl/huffman_code_bit_packer_core.sv
bench/huffman_code_bit_packer_checker.sv
bench/huffman_code_bit_packer_core_tb.sv
